@@ rtl/fps_pkg.sv @@
package fps_pkg;

	localparam int FPS_MAX_POINTS = 4096;
	localparam int FPS_COORD_BITS = 16;

	localparam int CFG_IDX_W = 2;
	localparam int CRD_W     = 16;
	localparam int DIST_W    = 17;
	localparam int IDX_W     = 12;

	// shared multiplier and root search widths
	localparam int OPND_W = 18;
	localparam int PROD_W = 36;
	localparam int ROOT_W = 17;
	localparam int WGT_W  = 34;
	localparam int NUM_W  = 66;
	localparam int ACC_W  = 70;

	localparam logic [CFG_IDX_W-1:0] REG_SEG_START_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_START_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_END_X   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_END_Y   = 2'd3;

	typedef struct packed {
		logic signed [CRD_W-1:0] point_x;
		logic signed [CRD_W-1:0] point_y;
		logic                    last_point;
	} fps_in_t;

	typedef struct packed {
		logic [DIST_W-1:0] max_distance;
		logic [IDX_W-1:0]  max_index;
		logic              count_overflow;
	} fps_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_FIN
	} fps_state_t;

	typedef enum logic [3:0] {
		OP_CR_A,
		OP_CR_B,
		OP_DOT_A,
		OP_DOT_B,
		OP_LEN_A,
		OP_LEN_B,
		OP_DD_A,
		OP_DD_B,
		OP_SQ_HH,
		OP_SQ_HL,
		OP_SQ_LL,
		OP_NONE
	} fps_op_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [WGT_W-1:0]  weight;
	} fps_req_t;

	typedef struct packed {
		logic              busy;
		logic [ROOT_W-1:0] root;
	} fps_rsp_t;

endpackage

@@ rtl/farthest_point_from_segment.sv @@
// Farthest point from a segment. Write the segment endpoints through the
// register port while idle, then stream the points of a run; the point with
// last_point set closes the run and yields one item with the largest distance
// (unsigned integer Q17.0, truncated), the index of the first point reaching it,
// and a flag if the run held more than MAX_POINTS points. A point is taken only
// while idle and passes through one shared 18x18 multiplier for the cross, dot,
// length and squared distance products and the square of the cross product, a
// root search start step, a bit-serial root search that resolves one distance
// bit per cycle, a step that sees the search done, and a finish step. A point
// past the limit goes straight to the finish step. A closing point waits there
// only while a previous result has not yet been taken.
module farthest_point_from_segment import fps_pkg::*; #(
	parameter int MAX_POINTS = FPS_MAX_POINTS,
	parameter int COORD_BITS = FPS_COORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CRD_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fps_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fps_out_t             out_data
);

	localparam int CNT_W   = $clog2(MAX_POINTS + 1);
	localparam int CW      = (COORD_BITS < CRD_W) ? COORD_BITS : CRD_W;
	localparam int CRD_XW  = CRD_W + 1;
	localparam logic [CRD_W-1:0]  CRD_MASK   = CRD_W'((33'd1 << CW) - 33'd1);
	localparam logic [CRD_XW-1:0] CRD_SPAN   = CRD_XW'(33'd1 << CW);
	localparam bit                CRD_SIGNED = (COORD_BITS <= CRD_W);

	function automatic logic signed [CRD_XW-1:0] to_coord(input logic [CRD_W-1:0] raw);
		logic [CRD_W-1:0]  v;
		logic [CRD_XW-1:0] u;
		v = raw & CRD_MASK;
		u = {1'b0, v};
		if (CRD_SIGNED && v[CW-1]) begin
			u = u - CRD_SPAN;
		end
		return $signed(u);
	endfunction

	fps_state_t state_q, state_nxt;
	fps_op_t    op_q, op_s1;

	logic [CRD_W-1:0] seg_sx_q, seg_sy_q, seg_ex_q, seg_ey_q;

	logic signed [CRD_XW-1:0] ax, ay, bx, by, px, py;
	logic signed [OPND_W-1:0] ux, uy, dx_in, dy_in;
	logic signed [OPND_W-1:0] dx_q, dy_q;
	logic                     last_q, skip_q;

	logic signed [OPND_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] cr_q, dot_q;
	logic [PROD_W-1:0]        cr_abs;
	logic [ROOT_W-1:0]        cr_hi, cr_lo;
	logic [WGT_W-1:0]         len_q, dd_q;
	logic [NUM_W-1:0]         crsq_q;
	logic                     in_span;

	fps_req_t srch_req;
	fps_rsp_t srch_rsp;

	logic [DIST_W-1:0]      best_q, best_nxt;
	logic [IDX_W-1:0]       pos_q, pos_nxt, pos_now;
	logic [CNT_W-1:0]       points_seen_q;
	logic [CNT_W+IDX_W-1:0] cnt_wide;
	logic                   ovf_q, ovf_nxt;
	logic                   better;
	logic                   skip_in;
	logic                   accept;
	logic                   fin_go;
	logic                   root_start;
	logic                   out_valid_q;
	fps_out_t               out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_sx_q <= '0;
			seg_sy_q <= '0;
			seg_ex_q <= '0;
			seg_ey_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SEG_START_X: seg_sx_q <= cfg_data;
				REG_SEG_START_Y: seg_sy_q <= cfg_data;
				REG_SEG_END_X:   seg_ex_q <= cfg_data;
				REG_SEG_END_Y:   seg_ey_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ax    = to_coord(seg_sx_q);
	assign ay    = to_coord(seg_sy_q);
	assign bx    = to_coord(seg_ex_q);
	assign by    = to_coord(seg_ey_q);
	assign px    = to_coord(in_data.point_x);
	assign py    = to_coord(in_data.point_y);
	assign ux    = OPND_W'(bx) - OPND_W'(ax);
	assign uy    = OPND_W'(by) - OPND_W'(ay);
	assign dx_in = OPND_W'(px) - OPND_W'(ax);
	assign dy_in = OPND_W'(py) - OPND_W'(ay);

	assign skip_in = (points_seen_q >= CNT_W'(MAX_POINTS));
	assign accept  = in_valid && in_ready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_NONE;
			op_s1   <= OP_NONE;
		end else begin
			state_q <= state_nxt;
			op_s1   <= (state_q == ST_MUL) ? op_q : OP_NONE;
			if (state_q == ST_IDLE) begin
				op_q <= OP_CR_A;
			end else if (state_q == ST_MUL && op_q != OP_NONE) begin
				op_q <= fps_op_t'(op_q + 4'd1);
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = skip_in ? ST_FIN : ST_MUL;
				end
			end
			ST_MUL: begin
				if (op_q == OP_NONE) begin
					state_nxt = ST_ROOT_GO;
				end
			end
			ST_ROOT_GO: state_nxt = ST_ROOT_WAIT;
			ST_ROOT_WAIT: begin
				if (!srch_rsp.busy) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		root_start = 1'b0;
		fin_go     = 1'b0;
		case (state_q)
			ST_IDLE:    in_ready   = 1'b1;
			ST_ROOT_GO: root_start = 1'b1;
			ST_FIN:     fin_go     = !last_q || !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dx_q   <= dx_in;
			dy_q   <= dy_in;
			last_q <= in_data.last_point;
			skip_q <= skip_in;
		end
	end

	// shared multiplier
	assign cr_abs = cr_q[PROD_W-1] ? PROD_W'(-cr_q) : PROD_W'(cr_q);
	assign cr_hi  = cr_abs[2*ROOT_W-1:ROOT_W];
	assign cr_lo  = cr_abs[ROOT_W-1:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op_q)
			OP_CR_A:  begin mul_a = dx_q; mul_b = uy; end
			OP_CR_B:  begin mul_a = dy_q; mul_b = ux; end
			OP_DOT_A: begin mul_a = dx_q; mul_b = ux; end
			OP_DOT_B: begin mul_a = dy_q; mul_b = uy; end
			OP_LEN_A: begin mul_a = ux;   mul_b = ux; end
			OP_LEN_B: begin mul_a = uy;   mul_b = uy; end
			OP_DD_A:  begin mul_a = dx_q; mul_b = dx_q; end
			OP_DD_B:  begin mul_a = dy_q; mul_b = dy_q; end
			OP_SQ_HH: begin mul_a = $signed({1'b0, cr_hi}); mul_b = $signed({1'b0, cr_hi}); end
			OP_SQ_HL: begin mul_a = $signed({1'b0, cr_hi}); mul_b = $signed({1'b0, cr_lo}); end
			OP_SQ_LL: begin mul_a = $signed({1'b0, cr_lo}); mul_b = $signed({1'b0, cr_lo}); end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		case (op_s1)
			OP_CR_A:  cr_q   <= prod_s1;
			OP_CR_B:  cr_q   <= cr_q - prod_s1;
			OP_DOT_A: dot_q  <= prod_s1;
			OP_DOT_B: dot_q  <= dot_q + prod_s1;
			OP_LEN_A: len_q  <= prod_s1[WGT_W-1:0];
			OP_LEN_B: len_q  <= len_q + prod_s1[WGT_W-1:0];
			OP_DD_A:  dd_q   <= prod_s1[WGT_W-1:0];
			OP_DD_B:  dd_q   <= dd_q + prod_s1[WGT_W-1:0];
			OP_SQ_HH: crsq_q <= NUM_W'(prod_s1[NUM_W-2*ROOT_W-1:0]) << (2 * ROOT_W);
			OP_SQ_HL: crsq_q <= crsq_q + (NUM_W'(prod_s1[2*ROOT_W-1:0]) << (ROOT_W + 1));
			OP_SQ_LL: crsq_q <= crsq_q + NUM_W'(prod_s1[2*ROOT_W-1:0]);
			default: ;
		endcase
	end

	// projection inside the segment: perpendicular distance, else distance to start
	assign in_span = (len_q != '0) && !dot_q[PROD_W-1]
		&& (dot_q <= $signed(PROD_W'(len_q)));

	assign srch_req.start  = root_start;
	assign srch_req.num    = in_span ? crsq_q : NUM_W'(dd_q);
	assign srch_req.weight = in_span ? len_q : WGT_W'(1);

	fps_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (srch_req),
		.rsp    (srch_rsp)
	);

	// run tracking
	assign cnt_wide = {{IDX_W{1'b0}}, points_seen_q};
	assign pos_now  = cnt_wide[IDX_W-1:0];
	assign better   = !skip_q && (srch_rsp.root > best_q);
	assign best_nxt = better ? srch_rsp.root : best_q;
	assign pos_nxt  = better ? pos_now : pos_q;
	assign ovf_nxt  = ovf_q | skip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q        <= '0;
			pos_q         <= '0;
			points_seen_q <= '0;
			ovf_q         <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (fin_go && last_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fin_go) begin
				if (last_q) begin
					best_q        <= '0;
					pos_q         <= '0;
					points_seen_q <= '0;
					ovf_q         <= 1'b0;
				end else begin
					best_q <= best_nxt;
					pos_q  <= pos_nxt;
					ovf_q  <= ovf_nxt;
					if (!skip_q) begin
						points_seen_q <= points_seen_q + CNT_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go && last_q) begin
			out_q.max_distance   <= best_nxt;
			out_q.max_index      <= pos_nxt;
			out_q.count_overflow <= ovf_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		srch_rsp.busy |-> state_q == ST_ROOT_WAIT)
		else $error("root search running outside its wait state");

	assert property (@(posedge clk) disable iff (!arst_n)
		points_seen_q <= CNT_W'(MAX_POINTS))
		else $error("point count above limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		fin_go && last_q |=> out_valid && points_seen_q == '0 && !ovf_q && best_q == '0)
		else $error("run end did not emit and clear");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && !fin_go |-> last_q && out_valid_q && !out_ready)
		else $error("finish stalled without a pending item");

endmodule

@@ rtl/fps_root.sv @@
module fps_root import fps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  fps_req_t req,
	output fps_rsp_t rsp
);

	logic [NUM_W-1:0]  num_q;
	logic [ACC_W-1:0]  s_q;
	logic [ACC_W-1:0]  a_q;
	logic [ACC_W-1:0]  b_q;
	logic [ACC_W-1:0]  trial;
	logic [ROOT_W-1:0] mask_q;
	logic [ROOT_W-1:0] root_q;
	logic              busy_q;
	logic              fits;

	// largest root with root^2 * weight <= num, one bit per cycle
	assign trial = s_q + a_q + b_q;
	assign fits  = (trial <= ACC_W'(num_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mask_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			mask_q <= {1'b1, {(ROOT_W-1){1'b0}}};
		end else if (busy_q) begin
			mask_q <= mask_q >> 1;
			if (mask_q[0]) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.num;
			s_q    <= '0;
			a_q    <= '0;
			b_q    <= ACC_W'(req.weight) << (2 * (ROOT_W - 1));
			root_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				s_q    <= trial;
				a_q    <= (a_q >> 1) + b_q;
				root_q <= root_q | mask_q;
			end else begin
				a_q <= a_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.root = root_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot(mask_q))
		else $error("root search bit mask not one-hot");

	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !$past(req.start) |-> s_q <= ACC_W'(num_q))
		else $error("root search partial square exceeds target");

endmodule
